// ----- src/maze_carver_backtracking_walk_unit_assert.svh -----
// Assertion macros used by the maze carver checker.
`ifndef MAZE_CARVER_BACKTRACKING_WALK_UNIT_ASSERT_SVH
`define MAZE_CARVER_BACKTRACKING_WALK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define MCBW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define MCBW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mcbw_pkg.sv -----
// Shared types, constants and helper functions of the maze carver.
`timescale 1ns / 1ps

package mcbw_pkg;

  localparam int MAX_DIM = 64;  // grid side limit in cells, before odd rounding
  localparam int REG_W  = 7;   // configuration register width
  localparam int IN_W   = 24;  // packed input item width
  localparam int OUT_W  = 16;  // packed result item width
  localparam int SZ_W   = 9;   // holds any grid size or request
  localparam int EP_W   = 8;   // visited epoch mark width
  localparam int MIN_DIM = 5;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SIZE = 2'd1;
  localparam logic [1:0] ERR_SIDE = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_ADV   = 1'b1;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [4:0] {
    S_CLR_R, S_IDLE, S_DECODE, S_ERR, S_CLR_S,
    S_MOD_A, S_RUN_A, S_PT_A, S_MOD_B, S_RUN_B, S_PT_B,
    S_DONE, S_TOP_RD, S_TOP_LD, S_NB_RD, S_NB_CHK, S_PICK, S_CARVE
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic start_ok;
    logic clr_step;
    logic mod_init;
    logic mod_sel;
    logic mod_step;
    logic emit_point;
    logic top_ld;
    logic nb_rd;
    logic nb_chk;
    logic pick;
    logic backtrack;
    logic carve;
    logic emit_done;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic mode_adv;
    logic start_err;
    logic epoch_wrap;
    logic clr_done;
    logic mod_done;
    logic walk_idle;
    logic cand_any;
    logic first_carve;
    logic nb_last;
    logic can_retry;
    logic carve_last;
  } sts_t;

  // Residue of an 8-bit value modulo 3: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3_8(input logic [7:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
    t = 3'(s[1:0]) + 3'(s[3:2]);
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  function automatic logic [2:0] popcnt4(input logic [3:0] m);
    return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
  endfunction

  // Value modulo a candidate count of one to four.
  function automatic logic [1:0] mod_count(input logic [7:0] v, input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = mod3_8(v);
      3'd4:    r = v[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Direction of the k-th set bit of the candidate mask, lowest first.
  function automatic logic [1:0] kth_set(input logic [3:0] m, input logic [1:0] k);
    logic [1:0] cnt;
    logic [1:0] d;
    cnt = 2'd0;
    d   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) begin
        if (cnt == k) d = 2'(i);
        cnt = cnt + 2'd1;
      end
    end
    return d;
  endfunction

endpackage

// ----- src/mcbw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mcbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- src/mcbw_ctrl.sv -----
// Sequencer of the maze carver: start, backtrack and carve steps.
`timescale 1ns / 1ps

module mcbw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mcbw_pkg::sts_t  sts,
  output mcbw_pkg::cmd_t  cmd
);

  import mcbw_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR_R;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLR_R:  if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (sts.mode_adv)        state_next = sts.walk_idle ? S_DONE : S_TOP_RD;
        else if (sts.start_err)  state_next = S_ERR;
        else                     state_next = sts.epoch_wrap ? S_CLR_S : S_MOD_A;
      end
      S_ERR:    if (sts.out_free) state_next = S_IDLE;
      S_CLR_S:  if (sts.clr_done) state_next = S_MOD_A;
      S_MOD_A:  state_next = S_RUN_A;
      S_RUN_A:  if (sts.mod_done) state_next = S_PT_A;
      S_PT_A:   if (sts.out_free) state_next = S_MOD_B;
      S_MOD_B:  state_next = S_RUN_B;
      S_RUN_B:  if (sts.mod_done) state_next = S_PT_B;
      S_PT_B:   if (sts.out_free) state_next = S_IDLE;
      S_DONE:   if (sts.out_free) state_next = S_IDLE;
      S_TOP_RD: state_next = S_TOP_LD;
      S_TOP_LD: state_next = S_NB_RD;
      S_NB_RD:  state_next = S_NB_CHK;
      S_NB_CHK: state_next = sts.nb_last ? S_PICK : S_NB_RD;
      S_PICK: begin
        if (sts.cand_any)         state_next = S_CARVE;
        else if (sts.first_carve) state_next = S_DONE;
        else                      state_next = sts.can_retry ? S_TOP_RD : S_DONE;
      end
      S_CARVE:  if (sts.out_free && sts.carve_last) state_next = S_IDLE;
      default:  state_next = S_CLR_R;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLR_R, S_CLR_S: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
      end
      S_DECODE: cmd.start_ok = !sts.mode_adv && !sts.start_err;
      S_ERR:    cmd.emit_err = sts.out_free;
      S_MOD_A:  cmd.mod_init = 1'b1;
      S_MOD_B: begin
        cmd.mod_init = 1'b1;
        cmd.mod_sel  = 1'b1;
      end
      S_RUN_A, S_RUN_B: cmd.mod_step = !sts.mod_done;
      S_PT_A, S_PT_B:   cmd.emit_point = sts.out_free;
      S_DONE:   cmd.emit_done = sts.out_free;
      S_TOP_LD: cmd.top_ld = 1'b1;
      S_NB_RD:  cmd.nb_rd = 1'b1;
      S_NB_CHK: cmd.nb_chk = 1'b1;
      S_PICK: begin
        cmd.pick      = sts.cand_any;
        cmd.backtrack = !sts.cand_any && !sts.first_carve;
      end
      S_CARVE:  cmd.carve = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- src/mcbw_dpath.sv -----
// Datapath of the maze carver: grid state, stores, neighbor checks, result register.
`timescale 1ns / 1ps

module mcbw_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr,
  input  logic                        cfg_index,
  input  logic [mcbw_pkg::REG_W-1:0]  cfg_data,
  input  logic                        in_mode,
  input  logic [mcbw_pkg::IN_W-1:0]   in_data,
  input  mcbw_pkg::cmd_t              cmd,
  output mcbw_pkg::sts_t              sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mcbw_pkg::OUT_W-1:0]  out_data,
  output logic                        out_last
);

  import mcbw_pkg::*;

  localparam int CW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int DPW   = $clog2(CELLS + 1);
  localparam int NW    = CW + 2;
  localparam logic signed [NW-1:0] ZERO_S = '0;

  // Registers
  logic [REG_W-1:0] maze_width, maze_height;
  logic [DW-1:0]    grid_w, grid_h;
  logic             mode_r, sa, ss, ea, es;
  logic [4:0]       sl, el;
  logic [7:0]       choice;
  logic [EP_W-1:0]  epoch;
  logic [AW-1:0]    clr_addr;
  logic             sel_r;
  logic [4:0]       rem;
  logic [DW-1:0]    span;
  logic [CW-1:0]    cur_x, cur_y;
  logic [DPW-1:0]   depth;
  logic             first_carve, finished;
  logic [1:0]       nb_idx;
  logic             nb_inb;
  logic [3:0]       mask;
  logic [1:0]       dir;
  logic             two_r, step_r;

  function automatic logic [SZ_W-1:0] sat_dim(input logic [REG_W-1:0] r);
    logic [SZ_W-1:0] v;
    v = SZ_W'(r);
    if (v > SZ_W'(MAX_DIM)) v = SZ_W'(MAX_DIM);
    return v;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_DIM) + AW'(x));
  endfunction

  // Start checks; an even size is rounded down to odd.
  logic [SZ_W-1:0] sat_w, sat_h;
  logic [DW-1:0]   fit_w, fit_h;
  logic            size_err, side_err;
  logic [1:0]      err_code;

  always_comb begin
    sat_w    = sat_dim(maze_width);
    sat_h    = sat_dim(maze_height);
    fit_w    = DW'(sat_w[0] ? sat_w : sat_w - SZ_W'(1));
    fit_h    = DW'(sat_h[0] ? sat_h : sat_h - SZ_W'(1));
    size_err = (sat_w < SZ_W'(MIN_DIM)) || (sat_h < SZ_W'(MIN_DIM));
    side_err = (sa == ea) && (ss == es);
    err_code = size_err ? ERR_SIZE : (side_err ? ERR_SIDE : ERR_NONE);
  end

  // Border point of the entrance or exit selected by sel_r.
  logic          ax_p, sd_p;
  logic [DW-1:0] across_size;
  logic [CW-1:0] along, across, px, py;

  always_comb begin
    ax_p        = sel_r ? ea : sa;
    sd_p        = sel_r ? es : ss;
    across_size = ax_p ? grid_w : grid_h;
    along       = CW'({rem, 1'b1});
    across      = sd_p ? CW'(across_size - DW'(1)) : '0;
    px          = ax_p ? across : along;
    py          = ax_p ? along : across;
  end

  // Neighbor two steps away in direction nb_idx.
  logic signed [NW-1:0] nx, ny, lim_x, lim_y;
  logic                 inb;
  logic [AW-1:0]        nb_addr;

  always_comb begin
    nx = $signed(NW'(cur_x));
    ny = $signed(NW'(cur_y));
    case (nb_idx)
      DIR_UP:    ny = ny - NW'(2);
      DIR_DOWN:  ny = ny + NW'(2);
      DIR_LEFT:  nx = nx - NW'(2);
      DIR_RIGHT: nx = nx + NW'(2);
      default:   nx = nx;
    endcase
    lim_x   = $signed(NW'(grid_w) - NW'(1));
    lim_y   = $signed(NW'(grid_h) - NW'(1));
    inb     = (nx > ZERO_S) && (nx < lim_x) && (ny > ZERO_S) && (ny < lim_y);
    nb_addr = cell_addr(CW'(nx), CW'(ny));
  end

  // One step of the carve in direction dir.
  logic [CW-1:0] nxt_x, nxt_y;

  always_comb begin
    nxt_x = cur_x;
    nxt_y = cur_y;
    case (dir)
      DIR_UP:    nxt_y = cur_y - CW'(1);
      DIR_DOWN:  nxt_y = cur_y + CW'(1);
      DIR_LEFT:  nxt_x = cur_x - CW'(1);
      DIR_RIGHT: nxt_x = cur_x + CW'(1);
      default:   nxt_x = cur_x;
    endcase
  end

  // Stores
  logic            vis_we, stk_we;
  logic [AW-1:0]   vis_waddr, stk_waddr, stk_raddr;
  logic [EP_W-1:0] vis_wdata, vis_rdata;
  logic [2*CW-1:0] stk_wdata, stk_rdata;
  logic [DPW-1:0]  depth_m1;
  logic            room;

  always_comb begin
    room      = depth < DPW'(CELLS);
    depth_m1  = depth - DPW'(1);
    stk_raddr = depth_m1[AW-1:0];
    vis_we    = cmd.carve || cmd.clr_step;
    vis_waddr = cmd.clr_step ? clr_addr : cell_addr(nxt_x, nxt_y);
    vis_wdata = cmd.clr_step ? '0 : epoch;
    stk_we    = (cmd.emit_point && !sel_r) || (cmd.carve && room);
    stk_waddr = cmd.emit_point ? '0 : depth[AW-1:0];
    stk_wdata = cmd.emit_point ? {py, px} : {nxt_y, nxt_x};
  end

  mcbw_ram #(.WIDTH(EP_W), .DEPTH(CELLS)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (nb_addr),
    .rdata (vis_rdata)
  );

  mcbw_ram #(.WIDTH(2 * CW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      maze_width  <= REG_W'(MIN_DIM);
      maze_height <= REG_W'(MIN_DIM);
      grid_w      <= DW'(MIN_DIM);
      grid_h      <= DW'(MIN_DIM);
      epoch       <= '0;
      clr_addr    <= '0;
      depth       <= '0;
      first_carve <= 1'b1;
      finished    <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index == REG_WIDTH)  maze_width  <= cfg_data;
        if (cfg_index == REG_HEIGHT) maze_height <= cfg_data;
      end
      if (cmd.start_ok) begin
        grid_w <= fit_w;
        grid_h <= fit_h;
        epoch  <= (epoch == '1) ? EP_W'(1) : epoch + EP_W'(1);
      end
      if (cmd.clr_step)
        clr_addr <= (clr_addr == AW'(CELLS - 1)) ? '0 : clr_addr + AW'(1);
      if (cmd.emit_point && !sel_r) depth <= DPW'(1);
      else if (cmd.carve && room)   depth <= depth + DPW'(1);
      else if (cmd.backtrack && sts.can_retry) depth <= depth - DPW'(2);
      else if (cmd.emit_done)       depth <= '0;
      if (cmd.emit_point && sel_r) begin
        first_carve <= 1'b1;
        finished    <= 1'b0;
      end
      if (cmd.pick) first_carve <= 1'b0;
      if (cmd.emit_done || cmd.emit_err) finished <= 1'b1;
      if (cmd.emit_point || cmd.carve || cmd.emit_done || cmd.emit_err)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      mode_r <= in_mode;
      sa     <= in_data[0];
      ss     <= in_data[1];
      sl     <= in_data[6:2];
      ea     <= in_data[7];
      es     <= in_data[8];
      el     <= in_data[13:9];
      choice <= in_data[21:14];
    end
    if (cmd.mod_init) begin
      sel_r <= cmd.mod_sel;
      rem   <= cmd.mod_sel ? el : sl;
      span  <= ((cmd.mod_sel ? ea : sa) ? grid_h >> 1 : grid_w >> 1) - DW'(1);
    end
    if (cmd.mod_step) rem <= rem - 5'(span);
    if (cmd.top_ld) begin
      cur_x  <= stk_rdata[CW-1:0];
      cur_y  <= stk_rdata[2*CW-1:CW];
      nb_idx <= 2'd0;
    end
    if (cmd.nb_rd) nb_inb <= inb;
    if (cmd.nb_chk) begin
      mask[nb_idx] <= nb_inb && (vis_rdata != epoch);
      nb_idx       <= nb_idx + 2'd1;
    end
    if (cmd.pick) begin
      dir    <= kth_set(mask, mod_count(choice, popcnt4(mask)));
      two_r  <= !first_carve;
      step_r <= 1'b0;
    end
    if (cmd.carve) begin
      cur_x  <= nxt_x;
      cur_y  <= nxt_y;
      step_r <= 1'b1;
    end
    if (cmd.emit_point) begin
      out_data <= {ERR_NONE, 1'b0, 1'b1, 6'(py), 6'(px)};
      out_last <= sel_r;
    end else if (cmd.carve) begin
      out_data <= {ERR_NONE, 1'b0, 1'b1, 6'(nxt_y), 6'(nxt_x)};
      out_last <= sts.carve_last;
    end else if (cmd.emit_done) begin
      out_data <= {ERR_NONE, 1'b1, 1'b0, 12'd0};
      out_last <= 1'b1;
    end else if (cmd.emit_err) begin
      out_data <= {err_code, 1'b1, 1'b0, 12'd0};
      out_last <= 1'b1;
    end
  end

  always_comb begin
    sts.out_free    = !out_valid || out_ready;
    sts.mode_adv    = (mode_r == MODE_ADV);
    sts.start_err   = (err_code != ERR_NONE);
    sts.epoch_wrap  = (epoch == '1);
    sts.clr_done    = (clr_addr == AW'(CELLS - 1));
    sts.mod_done    = SZ_W'(rem) < SZ_W'(span);
    sts.walk_idle   = finished || (depth == '0);
    sts.cand_any    = (mask != 4'd0);
    sts.first_carve = first_carve;
    sts.nb_last     = (nb_idx == 2'd3);
    sts.can_retry   = depth > DPW'(3);
    sts.carve_last  = step_r || !two_r;
  end

endmodule

// ----- src/maze_carver_backtracking_walk_unit.sv -----
// Top level of the randomized depth-first maze carver.
//
//  Channel   Signals                              Direction  Carries
//  s_axis    tvalid tready tdata[23:0] tuser      in         start or advance request
//  m_axis    tvalid tready tdata[15:0] tlast      out        opened cell or status result
//  cfg       cfg_valid cfg_ready cfg_index cfg_data  in      grid width and height registers
//
// Advance: the request is accepted and decoded, then each backtrack round reads the path
// top, tests the four neighbors and picks one, then the picked direction is carved. Start: the
// entrance and exit slots are reduced by a per-cycle subtraction; a rejected start only errors.
// After reset, and whenever the visited epoch wraps (every 255 starts), the visited store is
// swept clear one entry per cycle; no request is taken then.
// The result register lets the next request be taken while a result waits for
// m_axis_tready; configuration writes are always taken.
`timescale 1ns / 1ps

module maze_carver_backtracking_walk_unit (
  input  logic                        clk,
  input  logic                        rst,
  // tuser: mode
  // tdata: start_axis, start_side, start_slot[4:0], exit_axis, exit_side,
  //        exit_slot[4:0], choice_value[7:0], two zero bits
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [mcbw_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                        s_axis_tuser,
  // tdata: cell_x[5:0], cell_y[5:0], cell_valid, walk_done, error_code[1:0]
  // tlast: last_of_run
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mcbw_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [mcbw_pkg::REG_W-1:0]  cfg_data
);

  import mcbw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Registers are plain flops, so a write request is always taken.
  assign cfg_ready = 1'b1;

  mcbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcbw_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mode   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- src/mcbw_chk.sv -----
// Port-level checker of the maze carver, bound to the top level.
`timescale 1ns / 1ps
`include "maze_carver_backtracking_walk_unit_assert.svh"

module mcbw_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `MCBW_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")
  `MCBW_ASSERT_SAME(a_status_last, m_axis_tvalid && !m_axis_tdata[12], m_axis_tlast && m_axis_tdata[13], "status result not final or not done")
  `MCBW_ASSERT_SAME(a_err_shape, m_axis_tvalid && (m_axis_tdata[15:14] != 2'b00), !m_axis_tdata[12] && m_axis_tdata[13], "error result carries a cell")
  `MCBW_ASSERT_SAME(a_cell_shape, m_axis_tvalid && m_axis_tdata[12], !m_axis_tdata[13] && (m_axis_tdata[15:14] == 2'b00), "cell result flagged done or error")

endmodule

bind maze_carver_backtracking_walk_unit mcbw_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
